### rtl/core/tmcr_pkg.sv
// tmcr_pkg: shared constants and types of the tile map collision resolver
`default_nettype none

package tmcr_pkg;

    // geometry in world units and fixed point
    localparam int FRACTION_BITS = 8;
    localparam int TILE_SIZE     = 64;
    localparam int AGENT_SIZE    = 60;
    localparam int AGENT_RAD     = 30;
    localparam int MAX_COLUMNS   = 128;
    localparam int MAX_ROWS      = 128;

    localparam int TILE_FX       = TILE_SIZE << FRACTION_BITS;
    localparam int TILE_SHIFT    = $clog2(TILE_FX);
    localparam int HALF_TILE_FX  = TILE_FX / 2;
    localparam int AGENT_SPAN_FX = AGENT_SIZE << FRACTION_BITS;
    localparam int AGENT_RAD_FX  = AGENT_RAD << FRACTION_BITS;
    localparam int MIN_DIST_FX   = AGENT_RAD_FX + HALF_TILE_FX;

    // field widths
    localparam int POS_W   = 24;
    localparam int IDX_W   = 7;
    localparam int CFG_W   = 8;
    localparam int CIDX_W  = 1;
    localparam int EXT_W   = POS_W + 1;
    localparam int GRID_W  = EXT_W - TILE_SHIFT;
    localparam int DIFF_W  = POS_W + 2;

    // tile store split into four banks by column and row parity
    localparam int BANK_AW    = 2 * (IDX_W - 1);
    localparam int BANK_DEPTH = 1 << BANK_AW;
    localparam int NUM_BANKS  = 4;
    localparam int NUM_CORNERS = 4;

    // item modes
    localparam logic MODE_WRITE   = 1'b0;
    localparam logic MODE_RESOLVE = 1'b1;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] REG_MAP_COLUMNS = 1'b0;
    localparam logic [CIDX_W-1:0] REG_MAP_ROWS    = 1'b1;

    typedef logic signed [POS_W-1:0] pos_t;
    typedef logic [IDX_W-1:0]        tile_idx_t;
    typedef logic signed [DIFF_W-1:0] diff_t;

    // one resolve item between push steps
    typedef struct packed {
        logic                   hit;
        logic [NUM_CORNERS-1:0] solid;
        pos_t                   x;
        pos_t                   y;
        tile_idx_t              gx_lo;
        tile_idx_t              gx_hi;
        tile_idx_t              gy_lo;
        tile_idx_t              gy_hi;
    } tmcr_rec_t;

    // resolve item halfway through a push step
    typedef struct packed {
        tmcr_rec_t base;
        logic      x_neg;
        logic      y_neg;
        diff_t     x_depth;
        diff_t     y_depth;
    } tmcr_half_t;

endpackage

`default_nettype wire

### rtl/core/tmcr_item_if.sv
// tmcr_item_if: input channel carrying tile writes and resolve requests
`default_nettype none

interface tmcr_item_if import tmcr_pkg::*; ();
    logic      valid;
    logic      ready;
    logic      mode;
    tile_idx_t tile_column;
    tile_idx_t tile_row;
    logic      tile_solid;
    pos_t      agent_x;
    pos_t      agent_y;

    modport source (
        output valid, mode, tile_column, tile_row, tile_solid, agent_x, agent_y,
        input  ready
    );

    modport sink (
        input  valid, mode, tile_column, tile_row, tile_solid, agent_x, agent_y,
        output ready
    );
endinterface

`default_nettype wire

### rtl/core/tmcr_result_if.sv
// tmcr_result_if: output channel carrying resolved agent positions
`default_nettype none

interface tmcr_result_if import tmcr_pkg::*; ();
    logic valid;
    logic ready;
    pos_t resolved_x;
    pos_t resolved_y;
    logic hit_any;

    modport source (
        output valid, resolved_x, resolved_y, hit_any,
        input  ready
    );

    modport sink (
        input  valid, resolved_x, resolved_y, hit_any,
        output ready
    );
endinterface

`default_nettype wire

### rtl/core/tile_map_collision_resolve.sv
// tile_map_collision_resolve: banked tile map with pipelined agent push-out
// latency: a resolve result passes stage a, stage b and the half and push registers of every corner
// throughput: one transaction per cycle; every stage advances together and
//   holds while a finished result waits on the output
// reset: after rst_n the four 4096-entry tile banks are cleared to air, one
//   entry per bank per cycle, with no transaction accepted until done
// configuration writes are taken at any time, map size resets to 128 x 128
`default_nettype none

module tile_map_collision_resolve import tmcr_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    tmcr_item_if.sink              item,
    tmcr_result_if.source          result,
    input  wire logic              cfg_we,
    input  wire logic [CIDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data
);

    // saturate a widened position back to the 24-bit range
    function automatic pos_t sat_pos(input diff_t v);
        localparam diff_t HI = DIFF_W'((2 ** (POS_W - 1)) - 1);
        localparam diff_t LO = -DIFF_W'(2 ** (POS_W - 1));
        pos_t r;
        if (v > HI) r = HI[POS_W-1:0];
        else if (v < LO) r = LO[POS_W-1:0];
        else r = v[POS_W-1:0];
        return r;
    endfunction

    localparam diff_t DX_BIAS  = DIFF_W'(AGENT_RAD_FX - HALF_TILE_FX);
    localparam diff_t MIN_DIST = DIFF_W'(MIN_DIST_FX);

    // configuration registers
    logic [CFG_W-1:0] cols_reg;
    logic [CFG_W-1:0] rows_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= CFG_W'(MAX_COLUMNS);
            rows_reg <= CFG_W'(MAX_ROWS);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAP_COLUMNS: cols_reg <= cfg_data;
                REG_MAP_ROWS:    rows_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // clearing pass over the banks after reset
    logic               clear_active_reg;
    logic [BANK_AW-1:0] clear_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_active_reg <= 1'b1;
            clear_addr_reg   <= '0;
        end
        else if (clear_active_reg)
        begin
            clear_addr_reg <= clear_addr_reg + 1'b1;
            if (clear_addr_reg == BANK_AW'(BANK_DEPTH - 1))
                clear_active_reg <= 1'b0;
        end
    end

    // global pipeline advance
    logic out_valid;
    logic adv;
    assign adv = !out_valid || result.ready;
    assign item.ready = adv && !clear_active_reg;

    // stage a: accepted transaction
    logic      a_valid_reg;
    logic      a_mode_reg;
    tile_idx_t a_col_reg;
    tile_idx_t a_row_reg;
    logic      a_solid_reg;
    pos_t      a_x_reg;
    pos_t      a_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (adv)
            a_valid_reg <= item.valid && item.ready;
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            a_mode_reg  <= item.mode;
            a_col_reg   <= item.tile_column;
            a_row_reg   <= item.tile_row;
            a_solid_reg <= item.tile_solid;
            a_x_reg     <= item.agent_x;
            a_y_reg     <= item.agent_y;
        end
    end

    // corner tile indexes: the far corner is the near tile or the next one
    logic signed [EXT_W-1:0]  x_far;
    logic signed [EXT_W-1:0]  y_far;
    logic signed [GRID_W-1:0] gx_lo;
    logic signed [GRID_W-1:0] gx_hi;
    logic signed [GRID_W-1:0] gy_lo;
    logic signed [GRID_W-1:0] gy_hi;
    logic [CFG_W-1:0]         col_lim;
    logic [CFG_W-1:0]         row_lim;
    logic                     gx_lo_in;
    logic                     gx_hi_in;
    logic                     gy_lo_in;
    logic                     gy_hi_in;
    logic [NUM_CORNERS-1:0]   corner_in;

    assign x_far = {a_x_reg[POS_W-1], a_x_reg} + EXT_W'(AGENT_SPAN_FX);
    assign y_far = {a_y_reg[POS_W-1], a_y_reg} + EXT_W'(AGENT_SPAN_FX);
    assign gx_lo = {a_x_reg[POS_W-1], a_x_reg[POS_W-1:TILE_SHIFT]};
    assign gy_lo = {a_y_reg[POS_W-1], a_y_reg[POS_W-1:TILE_SHIFT]};
    assign gx_hi = x_far[EXT_W-1:TILE_SHIFT];
    assign gy_hi = y_far[EXT_W-1:TILE_SHIFT];

    assign col_lim = (cols_reg > CFG_W'(MAX_COLUMNS)) ? CFG_W'(MAX_COLUMNS) : cols_reg;
    assign row_lim = (rows_reg > CFG_W'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : rows_reg;

    assign gx_lo_in = !gx_lo[GRID_W-1] && (gx_lo[GRID_W-2:0] < (GRID_W-1)'(col_lim));
    assign gx_hi_in = !gx_hi[GRID_W-1] && (gx_hi[GRID_W-2:0] < (GRID_W-1)'(col_lim));
    assign gy_lo_in = !gy_lo[GRID_W-1] && (gy_lo[GRID_W-2:0] < (GRID_W-1)'(row_lim));
    assign gy_hi_in = !gy_hi[GRID_W-1] && (gy_hi[GRID_W-2:0] < (GRID_W-1)'(row_lim));

    assign corner_in[0] = gx_lo_in && gy_lo_in;
    assign corner_in[1] = gx_hi_in && gy_lo_in;
    assign corner_in[2] = gx_lo_in && gy_hi_in;
    assign corner_in[3] = gx_hi_in && gy_hi_in;

    logic tile_wr;
    assign tile_wr = adv && a_valid_reg && (a_mode_reg == MODE_WRITE);

    // stage b: corner data and bank read data
    logic                   b_valid_reg;
    logic [NUM_CORNERS-1:0] b_in_reg;
    tmcr_rec_t              b_rec_reg;
    logic [NUM_BANKS-1:0]   rd_bits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (adv)
            b_valid_reg <= a_valid_reg && (a_mode_reg == MODE_RESOLVE);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_in_reg        <= corner_in;
            b_rec_reg.hit   <= 1'b0;
            b_rec_reg.solid <= '0;
            b_rec_reg.x     <= a_x_reg;
            b_rec_reg.y     <= a_y_reg;
            b_rec_reg.gx_lo <= gx_lo[IDX_W-1:0];
            b_rec_reg.gx_hi <= gx_hi[IDX_W-1:0];
            b_rec_reg.gy_lo <= gy_lo[IDX_W-1:0];
            b_rec_reg.gy_hi <= gy_hi[IDX_W-1:0];
        end
    end

    // tile banks, bank index is {row parity, column parity}
    for (genvar b = 0; b < NUM_BANKS; b++)
    begin : g_bank
        logic               bank_mem [BANK_DEPTH];
        logic               rd_bit_reg;
        tile_idx_t          rd_col;
        tile_idx_t          rd_row;
        logic [BANK_AW-1:0] rd_addr;
        logic               wr_en;
        logic [BANK_AW-1:0] wr_addr;
        logic               wr_data;

        // read the tile of the 2x2 neighborhood whose parity fits this bank
        assign rd_col  = (gx_lo[0] == 1'(b % 2)) ? gx_lo[IDX_W-1:0] : gx_hi[IDX_W-1:0];
        assign rd_row  = (gy_lo[0] == 1'(b / 2)) ? gy_lo[IDX_W-1:0] : gy_hi[IDX_W-1:0];
        assign rd_addr = {rd_row[IDX_W-1:1], rd_col[IDX_W-1:1]};

        // clearing pass or one tile write
        assign wr_en   = clear_active_reg ||
                         (tile_wr && (a_col_reg[0] == 1'(b % 2)) &&
                          (a_row_reg[0] == 1'(b / 2)));
        assign wr_addr = clear_active_reg ? clear_addr_reg :
                         {a_row_reg[IDX_W-1:1], a_col_reg[IDX_W-1:1]};
        assign wr_data = clear_active_reg ? 1'b0 : a_solid_reg;

        always_ff @(posedge clk)
        begin
            if (wr_en)
                bank_mem[wr_addr] <= wr_data;
            if (adv)
                rd_bit_reg <= bank_mem[rd_addr];
        end

        assign rd_bits[b] = rd_bit_reg;
    end

    // solid corners, in corner order
    tmcr_rec_t rec_p0;

    always_comb
    begin
        logic [NUM_CORNERS-1:0] solid;
        for (int c = 0; c < NUM_CORNERS; c++)
        begin
            solid[c] = b_in_reg[c] && rd_bits[
                {(c / 2 == 1) ? b_rec_reg.gy_hi[0] : b_rec_reg.gy_lo[0],
                 (c % 2 == 1) ? b_rec_reg.gx_hi[0] : b_rec_reg.gx_lo[0]}];
        end
        rec_p0       = b_rec_reg;
        rec_p0.solid = solid;
        rec_p0.hit   = |solid;
    end

    // push steps, one per corner, each split over two stages
    logic       half_valid_reg [NUM_CORNERS];
    tmcr_half_t half_reg       [NUM_CORNERS];
    logic       push_valid_reg [NUM_CORNERS];
    tmcr_rec_t  push_reg       [NUM_CORNERS];
    logic       step_valid     [NUM_CORNERS];
    tmcr_rec_t  step_in        [NUM_CORNERS];

    assign step_valid[0] = b_valid_reg;
    assign step_in[0]    = rec_p0;

    for (genvar k = 0; k < NUM_CORNERS; k++)
    begin : g_push
        tmcr_half_t half_next;
        tmcr_rec_t  push_next;

        if (k > 0)
        begin : g_link
            assign step_valid[k] = push_valid_reg[k-1];
            assign step_in[k]    = push_reg[k-1];
        end

        // first half: offsets from the tile center and overlap depths
        always_comb
        begin
            tile_idx_t gx;
            tile_idx_t gy;
            diff_t     dx;
            diff_t     dy;
            gx = (k % 2 == 1) ? step_in[k].gx_hi : step_in[k].gx_lo;
            gy = (k / 2 == 1) ? step_in[k].gy_hi : step_in[k].gy_lo;
            dx = DIFF_W'(step_in[k].x) + DX_BIAS -
                 $signed({{(DIFF_W - IDX_W - TILE_SHIFT){1'b0}}, gx, {TILE_SHIFT{1'b0}}});
            dy = DIFF_W'(step_in[k].y) + DX_BIAS -
                 $signed({{(DIFF_W - IDX_W - TILE_SHIFT){1'b0}}, gy, {TILE_SHIFT{1'b0}}});
            half_next.base    = step_in[k];
            half_next.x_neg   = dx[DIFF_W-1];
            half_next.y_neg   = dy[DIFF_W-1];
            half_next.x_depth = dx[DIFF_W-1] ? MIN_DIST + dx : MIN_DIST - dx;
            half_next.y_depth = dy[DIFF_W-1] ? MIN_DIST + dy : MIN_DIST - dy;
        end

        // second half: push along the shallower axis, ties to y
        always_comb
        begin
            diff_t x_ext;
            diff_t y_ext;
            x_ext     = DIFF_W'(half_reg[k].base.x);
            y_ext     = DIFF_W'(half_reg[k].base.y);
            push_next = half_reg[k].base;
            if (half_reg[k].base.solid[k] && (half_reg[k].x_depth > 0) &&
                (half_reg[k].y_depth > 0))
            begin
                if (half_reg[k].x_depth < half_reg[k].y_depth)
                    push_next.x = sat_pos(half_reg[k].x_neg ? x_ext - half_reg[k].x_depth
                                                            : x_ext + half_reg[k].x_depth);
                else
                    push_next.y = sat_pos(half_reg[k].y_neg ? y_ext - half_reg[k].y_depth
                                                            : y_ext + half_reg[k].y_depth);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                half_valid_reg[k] <= 1'b0;
                push_valid_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                half_valid_reg[k] <= step_valid[k];
                push_valid_reg[k] <= half_valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                half_reg[k] <= half_next;
                push_reg[k] <= push_next;
            end
        end
    end

    // output register is the last push stage
    assign out_valid         = push_valid_reg[NUM_CORNERS-1];
    assign result.valid      = out_valid;
    assign result.resolved_x = push_reg[NUM_CORNERS-1].x;
    assign result.resolved_y = push_reg[NUM_CORNERS-1].y;
    assign result.hit_any    = push_reg[NUM_CORNERS-1].hit;

    // no transaction is taken while the banks are being cleared
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clear_active_reg |-> !item.ready)
        else $error("transaction accepted during clearing pass");

    // the clearing pass ends after the last bank entry
    a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (clear_active_reg && (clear_addr_reg == BANK_AW'(BANK_DEPTH - 1)))
        |=> !clear_active_reg)
        else $error("clearing pass did not end");

    // a tile write never turns into a result
    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && a_valid_reg && (a_mode_reg == MODE_WRITE)) |=> !b_valid_reg)
        else $error("tile write entered the resolve pipeline");

    // one push step moves the agent along one axis at most
    a_single_axis: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && half_valid_reg[0]) |=>
        ((push_reg[0].x == $past(half_reg[0].base.x)) ||
         (push_reg[0].y == $past(half_reg[0].base.y))))
        else $error("push moved both axes");

endmodule

`default_nettype wire

### tb/sv/tb.sv
// tb: self-checking testbench for the tile map collision resolver
`timescale 1ns / 100ps

module tb;
    import tmcr_pkg::*;

    // timing of the run
    localparam int RESET_CYCLES   = 11;
    localparam int DRAIN_CYCLES   = 16;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASE_ITEMS    = 280;

    // geometry in fixed point, worked out here from the base sizes
    localparam longint TILE_LEN  = longint'(TILE_SIZE) << FRACTION_BITS;
    localparam longint SPAN_LEN  = longint'(AGENT_SIZE) << FRACTION_BITS;
    localparam longint RAD_LEN   = longint'(AGENT_RAD) << FRACTION_BITS;
    localparam longint HALF_LEN  = TILE_LEN / 2;
    localparam longint PUSH_DIST = RAD_LEN + HALF_LEN;
    localparam longint POS_LO    = -(longint'(1) << (POS_W - 1));
    localparam longint POS_HI    = (longint'(1) << (POS_W - 1)) - 1;
    localparam int     TILE_I    = int'(TILE_LEN);

    // one row of stimulus: a register write or an item
    typedef struct packed {
        bit                  is_cfg;
        logic [CIDX_W-1:0]   reg_idx;
        logic [CFG_W-1:0]    reg_val;
        logic                mode;
        tile_idx_t           col;
        tile_idx_t           row;
        logic                solid;
        pos_t                ax;
        pos_t                ay;
        bit                  typed;
        pos_t                ex;
        pos_t                ey;
        logic                ehit;
    } stim_row_t;

    typedef struct packed {
        pos_t x;
        pos_t y;
        logic hit;
    } resolved_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic              cfg_we;
    logic [CIDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]  cfg_data;

    tmcr_item_if   item_ch();
    tmcr_result_if result_ch();

    tile_map_collision_resolve u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    bit tile_store [MAX_ROWS][MAX_COLUMNS];
    int map_cols = 128;
    int map_rows = 128;

    resolved_t resolved_q[$];
    stim_row_t directed_rows[$];
    int mismatch_count  = 0;
    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int hold_off_cycles = 0;
    int quiet_cycles    = 0;

    always #5 clk = ~clk;

    // fixed point helpers of the predictor
    function automatic longint floor_div(input longint a, input longint d);
        longint q;
        q = a / d;
        if ((a % d) != 0 && a < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic longint clamp_pos(input longint v);
        if (v < POS_LO)
            return POS_LO;
        if (v > POS_HI)
            return POS_HI;
        return v;
    endfunction

    // tile under one corner, solid and inside the map in use
    function automatic bit corner_on_solid(input longint px, input longint py,
                                           output longint cx, output longint cy);
        longint cols, rows, gx, gy;
        cols = (map_cols > MAX_COLUMNS) ? MAX_COLUMNS : map_cols;
        rows = (map_rows > MAX_ROWS) ? MAX_ROWS : map_rows;
        gx = floor_div(px, TILE_LEN);
        gy = floor_div(py, TILE_LEN);
        cx = 0;
        cy = 0;
        if (gx < 0 || gx >= cols || gy < 0 || gy >= rows)
            return 1'b0;
        if (!tile_store[gy][gx])
            return 1'b0;
        cx = gx * TILE_LEN + HALF_LEN;
        cy = gy * TILE_LEN + HALF_LEN;
        return 1'b1;
    endfunction

    // push the agent out along the shallower axis, ties go to y
    function automatic void push_clear(inout longint x, inout longint y,
                                       input longint cx, input longint cy);
        longint dx, dy, xd, yd;
        dx = x + RAD_LEN - cx;
        dy = y + RAD_LEN - cy;
        xd = PUSH_DIST - ((dx < 0) ? -dx : dx);
        yd = PUSH_DIST - ((dy < 0) ? -dy : dy);
        if (xd > 0 && yd > 0)
        begin
            if (xd < yd)
                x = clamp_pos((dx < 0) ? x - xd : x + xd);
            else
                y = clamp_pos((dy < 0) ? y - yd : y + yd);
        end
    endfunction

    // corners come from the incoming position, pushes chain in corner order
    function automatic resolved_t resolve_agent(input pos_t ax, input pos_t ay);
        longint    x, y;
        longint    cx [NUM_CORNERS];
        longint    cy [NUM_CORNERS];
        bit        on_solid [NUM_CORNERS];
        resolved_t res;
        x = ax;
        y = ay;
        res.hit = 1'b0;
        for (int i = 0; i < NUM_CORNERS; i++)
            on_solid[i] = corner_on_solid(x + (((i & 1) != 0) ? SPAN_LEN : 0),
                                          y + (((i & 2) != 0) ? SPAN_LEN : 0),
                                          cx[i], cy[i]);
        for (int i = 0; i < NUM_CORNERS; i++)
        begin
            if (on_solid[i])
            begin
                res.hit = 1'b1;
                push_clear(x, y, cx[i], cy[i]);
            end
        end
        res.x = pos_t'(x);
        res.y = pos_t'(y);
        return res;
    endfunction

    // row builders for the directed part
    function automatic stim_row_t tile_wr(input int col, input int row, input bit solid);
        stim_row_t r;
        r = '0;
        r.mode  = MODE_WRITE;
        r.col   = tile_idx_t'(col);
        r.row   = tile_idx_t'(row);
        r.solid = solid;
        r.ax    = pos_t'($urandom());
        r.ay    = pos_t'($urandom());
        return r;
    endfunction

    function automatic stim_row_t agent_rs(input int x, input int y);
        stim_row_t r;
        r = '0;
        r.mode  = MODE_RESOLVE;
        r.col   = tile_idx_t'($urandom());
        r.row   = tile_idx_t'($urandom());
        r.solid = 1'($urandom());
        r.ax    = pos_t'(x);
        r.ay    = pos_t'(y);
        return r;
    endfunction

    // nothing solid under the box: position comes back as it went in
    function automatic stim_row_t agent_rs_clear(input int x, input int y);
        stim_row_t r;
        r = agent_rs(x, y);
        r.typed = 1'b1;
        r.ex    = r.ax;
        r.ey    = r.ay;
        r.ehit  = 1'b0;
        return r;
    endfunction

    function automatic stim_row_t reg_wr(input logic [CIDX_W-1:0] idx,
                                         input logic [CFG_W-1:0] val);
        stim_row_t r;
        r = '0;
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    // append one row to the directed table
    function automatic void add_row(input stim_row_t r);
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    // coordinate around the first few tiles, often on an edge or a centre
    function automatic int near_coord();
        int k, off;
        k = int'($urandom_range(10)) - 1;
        case ($urandom_range(9))
            0: off = 0;
            1: off = TILE_I - 1;
            2: off = TILE_I - int'(SPAN_LEN);
            3: off = TILE_I - int'(SPAN_LEN) - 1;
            4: off = int'(HALF_LEN - RAD_LEN);
            default: off = int'($urandom_range(TILE_I - 1));
        endcase
        return k * TILE_I + off;
    endfunction

    // random item: mostly map writes and resolves around a small level
    function automatic stim_row_t random_row();
        stim_row_t r;
        int        pick;
        pick = int'($urandom_range(99));
        if (pick < 30)
        begin
            if ($urandom_range(4) == 0)
                r = tile_wr(int'($urandom_range(127)), int'($urandom_range(127)),
                            1'($urandom()));
            else
                r = tile_wr(int'($urandom_range(9)), int'($urandom_range(9)),
                            $urandom_range(99) < 55);
        end
        else if (pick < 90)
            r = agent_rs(near_coord(), near_coord());
        else
            r = agent_rs(int'($urandom()), int'($urandom()));
        return r;
    endfunction

    // drive one item and update the predictor when it is taken
    task automatic send_item(input stim_row_t r);
        resolved_t exp_res;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.mode        <= r.mode;
        item_ch.tile_column <= r.col;
        item_ch.tile_row    <= r.row;
        item_ch.tile_solid  <= r.solid;
        item_ch.agent_x     <= r.ax;
        item_ch.agent_y     <= r.ay;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        if (r.mode == MODE_WRITE)
            tile_store[r.row][r.col] = r.solid;
        else
        begin
            if (r.typed)
                exp_res = '{x: r.ex, y: r.ey, hit: r.ehit};
            else
                exp_res = resolve_agent(r.ax, r.ay);
            resolved_q.insert(resolved_q.size(), exp_res);
        end
        @(negedge clk);
    endtask

    // stop offering and let the pipe empty, tile writes included
    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        while (resolved_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        if (idx == REG_MAP_COLUMNS)
            map_cols = int'(val);
        else if (idx == REG_MAP_ROWS)
            map_rows = int'(val);
    endtask

    task automatic run_phase(input int n_items, input int s_idle, input int r_idle,
                             input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] rows,
                             input int hold);
        wait_drained();
        write_reg(REG_MAP_COLUMNS, cols);
        write_reg(REG_MAP_ROWS, rows);
        send_idle_pct   = s_idle;
        recv_idle_pct   = r_idle;
        hold_off_cycles = hold;
        repeat (n_items) send_item(random_row());
    endtask

    // result side: random stalls plus one long hold-off when asked
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_off_cycles = hold_off_cycles - 1;
            end
            else
                result_ch.ready <= !(recv_idle_pct != 0 &&
                                     $urandom_range(99) < recv_idle_pct);
        end
    end

    // compare each result transaction with the oldest expected position
    always @(posedge clk)
    begin
        resolved_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (resolved_q.size() == 0)
            begin
                $error("result with no resolve pending: x %0d y %0d hit %0d",
                       result_ch.resolved_x, result_ch.resolved_y, result_ch.hit_any);
                mismatch_count++;
            end
            else
            begin
                want = resolved_q.pop_front();
                if (result_ch.resolved_x !== want.x)
                begin
                    $error("resolved_x: expected %0d, got %0d", want.x, result_ch.resolved_x);
                    mismatch_count++;
                end
                if (result_ch.resolved_y !== want.y)
                begin
                    $error("resolved_y: expected %0d, got %0d", want.y, result_ch.resolved_y);
                    mismatch_count++;
                end
                if (result_ch.hit_any !== want.hit)
                begin
                    $error("hit_any: expected %0d, got %0d", want.hit, result_ch.hit_any);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        item_ch.valid       = 1'b0;
        item_ch.mode        = MODE_WRITE;
        item_ch.tile_column = '0;
        item_ch.tile_row    = '0;
        item_ch.tile_solid  = 1'b0;
        item_ch.agent_x     = '0;
        item_ch.agent_y     = '0;
        cfg_we              = 1'b0;
        cfg_index           = REG_MAP_COLUMNS;
        cfg_data            = '0;

        // directed rows: empty map first, then pushes and map edges
        add_row(agent_rs_clear(0, 0));
        add_row(agent_rs_clear(int'(POS_LO), int'(POS_LO)));
        add_row(agent_rs_clear(int'(POS_HI), int'(POS_HI)));
        add_row(agent_rs_clear(int'(POS_HI), int'(POS_LO)));
        add_row(tile_wr(0, 0, 1'b1));
        // all four corners on one tile, later duplicates no longer overlap
        add_row(agent_rs(0, 0));
        // agent centre on the tile centre pushes the positive way
        add_row(agent_rs(int'(HALF_LEN - RAD_LEN), int'(HALF_LEN - RAD_LEN)));
        add_row(tile_wr(0, 0, 1'b0));
        add_row(tile_wr(1, 0, 1'b1));
        // shallow overlap along x
        add_row(agent_rs(2048, 0));
        add_row(tile_wr(0, 0, 1'b1));
        // left corners fall off the map
        add_row(agent_rs(-1024, 0));
        add_row(tile_wr(127, 127, 1'b1));
        add_row(agent_rs(127 * TILE_I, 127 * TILE_I));
        add_row(agent_rs(127 * TILE_I + 8000, 127 * TILE_I + 8000));
        // one-tile map
        add_row(reg_wr(REG_MAP_COLUMNS, 8'd1));
        add_row(reg_wr(REG_MAP_ROWS, 8'd1));
        add_row(agent_rs(2048, 0));
        // zero columns leaves no tile in the map
        add_row(reg_wr(REG_MAP_COLUMNS, 8'd0));
        add_row(agent_rs_clear(0, 0));
        // sizes above the store act as the store size
        add_row(reg_wr(REG_MAP_COLUMNS, 8'd255));
        add_row(reg_wr(REG_MAP_ROWS, 8'd255));
        add_row(agent_rs(127 * TILE_I, 127 * TILE_I));
        add_row(agent_rs(128 * TILE_I, 0));
        add_row(tile_wr(127, 127, 1'b0));

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
            begin
                wait_drained();
                write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            end
            else
                send_item(directed_rows[i]);
        end

        // random phases: sender idles less, then more, then neither
        run_phase(PHASE_ITEMS, 11, 59, 8'd128, 8'd128, 0);
        run_phase(PHASE_ITEMS, 59, 11, 8'd9, 8'd5, 0);
        run_phase(PHASE_ITEMS, 0, 0, 8'd255, 8'd2, 0);
        // receiver holds off while items keep coming, so the pipe fills
        run_phase(PHASE_ITEMS, 0, 0, 8'd6, 8'd200, HOLD_CYCLES);

        wait_drained();
        if (mismatch_count == 0 && resolved_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
